@@ hdl/assert_macros.svh @@
// Assertion helpers used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mtcp_pkg.sv @@
package mtcp_pkg;

   localparam int unsigned PayloadBufferDefault = 512;
   localparam int unsigned VlqMaxBytes = 4;
   localparam int unsigned VlqW = 7 * VlqMaxBytes;
   localparam int unsigned TickW = 32;
   localparam int unsigned TempoW = 24;
   localparam int unsigned IndexW = 9;

   localparam logic [TempoW-1:0] TempoDefault = 24'd500000;

   localparam logic [7:0] StatusSysex = 8'hF0;
   localparam logic [7:0] StatusEscape = 8'hF7;
   localparam logic [7:0] StatusMeta = 8'hFF;
   localparam logic [7:0] MetaSetTempo = 8'h51;

   localparam logic [1:0] KindChannel = 2'd0;
   localparam logic [1:0] KindSysex = 2'd1;
   localparam logic [1:0] KindMeta = 2'd2;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_MTYPE,
      PH_LEN,
      PH_PAYLOAD,
      PH_DATA1,
      PH_DATA2
   } phase_type;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       track_start;
      logic       track_end;
   } req_beat_type;

   typedef struct packed {
      logic [TickW-1:0]  event_tick;
      logic [1:0]        event_kind;
      logic [7:0]        status_byte;
      logic [7:0]        meta_code;
      logic [7:0]        first_data;
      logic [7:0]        second_data;
      logic [1:0]        event_length;
      logic [7:0]        payload_byte;
      logic              payload_valid;
      logic [IndexW-1:0] payload_index;
      logic              event_end;
      logic [TempoW-1:0] quarter_tempo;
   } rsp_beat_type;

   // Number of data bytes that follow a channel status.
   function automatic logic [1:0] data_need(input logic [7:0] status);
      logic [1:0] need;
      unique case (status[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: need = 2'd2;
         4'hC, 4'hD:                   need = 2'd1;
         default:                      need = 2'd0;
      endcase
      return need;
   endfunction

endpackage

@@ hdl/mtcp_core.sv @@
module mtcp_core #(
   parameter int unsigned PAYLOAD_BUFFER = mtcp_pkg::PayloadBufferDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat_valid,
   input  mtcp_pkg::req_beat_type beat,
   output logic                   result_valid,
   output mtcp_pkg::rsp_beat_type result
);
   import mtcp_pkg::*;

   localparam int unsigned PosW = $clog2(PAYLOAD_BUFFER);
   localparam logic [PosW-1:0] PosMax = PosW'(PAYLOAD_BUFFER - 1);
   localparam logic [PosW-1:0] CapSysex = PosW'(PAYLOAD_BUFFER - 1);
   localparam logic [PosW-1:0] CapMeta = PosW'(PAYLOAD_BUFFER - 2);

   phase_type         phase_ff, phase_in;
   logic [VlqW-1:0]   vlq_ff, vlq_in;
   logic [2:0]        vcnt_ff, vcnt_in;
   logic [TickW-1:0]  tick_ff, tick_in;
   logic [7:0]        run_ff, run_in;
   logic [7:0]        cur_ff, cur_in;
   logic [7:0]        meta_ff, meta_in;
   logic [7:0]        held_ff, held_in;
   logic [VlqW-1:0]   left_ff, left_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [TempoW-1:0] tempo_ff, tempo_in;
   logic [TempoW-1:0] gather_ff, gather_in;

   // State as seen by this byte, after a track start has cleared it.
   phase_type         phase;
   logic [VlqW-1:0]   vlq;
   logic [2:0]        vcnt;
   logic [TickW-1:0]  tick;
   logic [7:0]        run;
   logic [7:0]        cur;
   logic [7:0]        meta;
   logic [7:0]        held;
   logic [VlqW-1:0]   left;
   logic [PosW-1:0]   pos;
   logic [TempoW-1:0] tempo;
   logic [TempoW-1:0] gather;

   logic [7:0]      b;
   logic            fin;
   logic [VlqW-1:0] vlq_shift;
   logic [2:0]      vcnt_inc;
   logic            take_done;
   logic [VlqW-1:0] fresh;
   logic            redelta;
   logic            consumed;
   logic [7:0]      rs;
   logic [1:0]      need;
   logic [PosW-1:0] cap;
   logic            store;
   logic            last;

   logic            put;
   logic            put_chan;
   logic [1:0]      chan_len;
   logic [7:0]      chan_d1;
   logic [7:0]      chan_d2;
   logic            blk_valid;
   logic [PosW-1:0] blk_idx;
   logic            blk_last;

   always_comb begin
      phase = phase_ff;
      vlq = vlq_ff;
      vcnt = vcnt_ff;
      tick = tick_ff;
      run = run_ff;
      cur = cur_ff;
      meta = meta_ff;
      held = held_ff;
      left = left_ff;
      pos = pos_ff;
      tempo = tempo_ff;
      gather = gather_ff;
      if (beat.track_start) begin
         phase = PH_DELTA;
         vlq = '0;
         vcnt = '0;
         tick = '0;
         run = '0;
         cur = '0;
         meta = '0;
         held = '0;
         left = '0;
         pos = '0;
         tempo = TempoDefault;
         gather = '0;
      end

      b = beat.track_byte;
      fin = beat.track_end;
      vlq_shift = {vlq[VlqW-8:0], b[6:0]};
      vcnt_inc = vcnt + 3'd1;
      take_done = !b[7] || (vcnt_inc >= 3'(VlqMaxBytes));
      fresh = VlqW'(b[6:0]);

      phase_in = phase;
      vlq_in = vlq;
      vcnt_in = vcnt;
      tick_in = tick;
      run_in = run;
      cur_in = cur;
      meta_in = meta;
      held_in = held;
      left_in = left;
      pos_in = pos;
      tempo_in = tempo;
      gather_in = gather;

      redelta = 1'b0;
      consumed = b[7];
      rs = consumed ? b : run;
      need = 2'd0;
      cap = (cur == StatusMeta) ? CapMeta : CapSysex;
      store = pos < cap;
      last = 1'b0;

      put = 1'b0;
      put_chan = 1'b0;
      chan_len = 2'd0;
      chan_d1 = '0;
      chan_d2 = '0;
      blk_valid = 1'b0;
      blk_idx = '0;
      blk_last = 1'b0;

      unique case (phase)
         PH_DELTA: begin
            if (take_done || fin) begin
               tick_in = tick + 32'(vlq_shift);
               vlq_in = '0;
               vcnt_in = '0;
               phase_in = PH_STATUS;
            end else begin
               vlq_in = vlq_shift;
               vcnt_in = vcnt_inc;
            end
         end
         PH_STATUS: begin
            if (b == StatusSysex || b == StatusEscape) begin
               run_in = '0;
               cur_in = b;
               meta_in = '0;
               vlq_in = '0;
               vcnt_in = '0;
               if (fin) begin
                  put = 1'b1;
                  blk_last = 1'b1;
                  phase_in = PH_DELTA;
               end else begin
                  phase_in = PH_LEN;
               end
            end else if (b == StatusMeta) begin
               run_in = '0;
               cur_in = b;
               meta_in = '0;
               phase_in = fin ? PH_DELTA : PH_MTYPE;
            end else begin
               run_in = rs;
               cur_in = rs;
               need = data_need(rs);
               phase_in = PH_DELTA;
               if (need == 2'd0) begin
                  put = 1'b1;
                  put_chan = 1'b1;
                  chan_len = 2'd1;
                  redelta = !consumed;
               end else if (consumed) begin
                  if (fin) begin
                     put = 1'b1;
                     put_chan = 1'b1;
                  end else begin
                     phase_in = PH_DATA1;
                  end
               end else if (need == 2'd1) begin
                  put = 1'b1;
                  put_chan = 1'b1;
                  chan_len = 2'd2;
                  chan_d1 = b;
               end else if (fin) begin
                  put = 1'b1;
                  put_chan = 1'b1;
                  redelta = 1'b1;
               end else begin
                  held_in = b;
                  phase_in = PH_DATA2;
               end
            end
         end
         PH_MTYPE: begin
            meta_in = b;
            vlq_in = '0;
            vcnt_in = '0;
            if (fin) begin
               put = 1'b1;
               blk_last = 1'b1;
               phase_in = PH_DELTA;
            end else begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            vlq_in = vlq_shift;
            vcnt_in = vcnt_inc;
            if (fin) begin
               put = 1'b1;
               blk_last = 1'b1;
               phase_in = PH_DELTA;
            end else if (take_done) begin
               left_in = vlq_shift;
               pos_in = '0;
               gather_in = '0;
               if (vlq_shift == '0) begin
                  put = 1'b1;
                  blk_last = 1'b1;
                  phase_in = PH_DELTA;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            if (take_done || fin) begin
               vlq_in = '0;
               vcnt_in = '0;
            end
         end
         PH_PAYLOAD: begin
            // The tempo is the first three payload bytes of a Set Tempo event, taken while the tempo holds its default.
            if (cur == StatusMeta && meta == MetaSetTempo && pos < PosW'(3)) begin
               gather_in = {gather[TempoW-9:0], b};
               if (pos == PosW'(2) && tempo == TempoDefault) begin
                  tempo_in = {gather[TempoW-9:0], b};
               end
            end
            if (left != '0) begin
               left_in = left - VlqW'(1);
            end
            if (pos != PosMax) begin
               pos_in = pos + PosW'(1);
            end
            last = (left_in == '0) || fin;
            if (store || last) begin
               put = 1'b1;
               blk_valid = store;
               blk_idx = pos;
               blk_last = last;
            end
            if (last) begin
               phase_in = PH_DELTA;
            end
         end
         PH_DATA1: begin
            phase_in = PH_DELTA;
            need = data_need(cur);
            if (need == 2'd1) begin
               put = 1'b1;
               put_chan = 1'b1;
               chan_len = 2'd2;
               chan_d1 = b;
            end else if (fin) begin
               put = 1'b1;
               put_chan = 1'b1;
               redelta = 1'b1;
            end else begin
               held_in = b;
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            put = 1'b1;
            put_chan = 1'b1;
            chan_len = 2'd3;
            chan_d1 = held;
            chan_d2 = b;
            phase_in = PH_DELTA;
         end
         default: begin
            redelta = 1'b1;
         end
      endcase

      // A byte that the channel event did not take starts the next delta.
      if (redelta) begin
         if (!b[7] || fin) begin
            tick_in = tick + 32'(fresh);
            vlq_in = '0;
            vcnt_in = '0;
            phase_in = PH_STATUS;
         end else begin
            vlq_in = fresh;
            vcnt_in = 3'd1;
            phase_in = PH_DELTA;
         end
      end

      if (fin) begin
         phase_in = PH_DELTA;
         vlq_in = '0;
         vcnt_in = '0;
         left_in = '0;
         pos_in = '0;
      end
   end

   always_comb begin
      result_valid = beat_valid && put;
      result.event_tick = tick;
      result.status_byte = cur_in;
      result.quarter_tempo = tempo_in;
      if (put_chan) begin
         result.event_kind = KindChannel;
         result.meta_code = '0;
         result.first_data = chan_d1;
         result.second_data = chan_d2;
         result.event_length = chan_len;
         result.payload_byte = '0;
         result.payload_valid = 1'b0;
         result.payload_index = '0;
         result.event_end = 1'b1;
      end else begin
         result.event_kind = (cur_in == StatusMeta) ? KindMeta : KindSysex;
         result.meta_code = (cur_in == StatusMeta) ? meta_in : '0;
         result.first_data = '0;
         result.second_data = '0;
         result.event_length = 2'd0;
         result.payload_byte = blk_valid ? b : '0;
         result.payload_valid = blk_valid;
         result.payload_index = blk_valid ? IndexW'(blk_idx) : '0;
         result.event_end = blk_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         vlq_ff <= '0;
         vcnt_ff <= '0;
         tick_ff <= '0;
         run_ff <= '0;
         cur_ff <= '0;
         meta_ff <= '0;
         held_ff <= '0;
         left_ff <= '0;
         pos_ff <= '0;
         tempo_ff <= TempoDefault;
         gather_ff <= '0;
      end else if (beat_valid) begin
         phase_ff <= phase_in;
         vlq_ff <= vlq_in;
         vcnt_ff <= vcnt_in;
         tick_ff <= tick_in;
         run_ff <= run_in;
         cur_ff <= cur_in;
         meta_ff <= meta_in;
         held_ff <= held_in;
         left_ff <= left_in;
         pos_ff <= pos_in;
         tempo_ff <= tempo_in;
         gather_ff <= gather_in;
      end
   end

endmodule

@@ hdl/midi_track_chunk_parser.sv @@
// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_ready  req_beat: one track byte, start and end flags
// rsp_      out        rsp_valid/rsp_ready  rsp_beat: one event or payload result
//
// A byte is registered on acceptance and parsed while the skid entry is empty; its
// result is registered. One byte per cycle is sustained while the skid entry is empty.
// The result side has an output register and one skid entry. While the skid entry
// is full the parser holds, and req_ready drops once the input register holds a byte.
// Reset is synchronous and returns the parser to the delta phase, tempo 500000.
`include "assert_macros.svh"

module midi_track_chunk_parser #(
   parameter int unsigned PAYLOAD_BUFFER = mtcp_pkg::PayloadBufferDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mtcp_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mtcp_pkg::rsp_beat_type rsp_beat
);
   import mtcp_pkg::*;

   logic         in_valid_ff;
   req_beat_type in_beat_ff;
   logic         out_valid_ff;
   rsp_beat_type out_beat_ff;
   logic         skid_valid_ff;
   rsp_beat_type skid_beat_ff;

   logic         advance;
   logic         core_valid;
   rsp_beat_type core_result;
   logic         push;
   logic         pop;

   assign advance = in_valid_ff && !skid_valid_ff;
   assign req_ready = !in_valid_ff || !skid_valid_ff;
   assign push = core_valid;
   assign pop = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_beat = out_beat_ff;

   mtcp_core #(
      .PAYLOAD_BUFFER(PAYLOAD_BUFFER)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (advance),
      .beat        (in_beat_ff),
      .result_valid(core_valid),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_beat_ff <= req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_beat_ff <= skid_beat_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_beat_ff <= core_result;
      end
      if (push && out_valid_ff && !pop) begin
         skid_beat_ff <= core_result;
      end
   end

   `MTCP_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry without output entry")
   `MTCP_ASSERT_NEXT(a_stall_fills_skid, clock, reset, push && out_valid_ff && !rsp_ready,
      skid_valid_ff, "stalled result was dropped")
   `MTCP_ASSERT_NEXT(a_byte_consumed, clock, reset, advance,
      !in_valid_ff || $past(req_valid && req_ready), "parsed byte was not retired")
   `MTCP_ASSERT_NOW(a_channel_closes, clock, reset,
      rsp_valid && rsp_beat.event_kind == KindChannel,
      rsp_beat.event_end && !rsp_beat.payload_valid, "channel result malformed")

endmodule

@@ test/tb_midi_track_chunk_parser.sv @@
`timescale 1ns / 1ps

module tb_midi_track_chunk_parser;
   import mtcp_pkg::*;

   localparam int unsigned IdlePercent    = 28;
   localparam int unsigned RandomBytes    = 520;
   localparam int unsigned SteadySendFrom = 600;
   localparam int unsigned SteadySendTo   = 900;
   localparam int unsigned HoldOffStart   = 1000;
   localparam int unsigned HoldOffCycles  = 300;
   localparam int unsigned SteadyTakeFrom = 1500;
   localparam int unsigned SteadyTakeTo   = 2000;
   localparam int unsigned DrainCycles    = 20;
   localparam int unsigned CycleLimit     = 400000;

   localparam logic [7:0] MetaEndOfTrack        = 8'h2F;
   localparam logic [7:0] MetaSequencerSpecific = 8'h7F;

   // Expected-result tracker: follows the parser state byte by byte and
   // queues the results each accepted byte should produce.
   class track_event_checker;
      rsp_beat_type awaited_events[$];
      int unsigned  fail_count;
      phase_type    phase;
      logic [31:0]  vlq_acc;
      int unsigned  vlq_count;
      logic [31:0]  tick;
      logic [7:0]   run_status;
      logic [7:0]   cur_status;
      logic [7:0]   cur_meta;
      logic [7:0]   held;
      logic [31:0]  remaining;
      logic [31:0]  pos;
      logic [23:0]  tempo;
      logic [23:0]  tempo_acc;

      function new();
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         phase      = PH_DELTA;
         vlq_acc    = '0;
         vlq_count  = 0;
         tick       = '0;
         run_status = '0;
         cur_status = '0;
         cur_meta   = '0;
         held       = '0;
         remaining  = '0;
         pos        = '0;
         tempo      = TempoDefault;
         tempo_acc  = '0;
      endfunction

      function void clear_vlq();
         vlq_acc   = '0;
         vlq_count = 0;
      endfunction

      function bit gather_vlq(input logic [7:0] b);
         vlq_acc = {vlq_acc[24:0], b[6:0]};
         vlq_count++;
         return !b[7] || vlq_count >= VlqMaxBytes;
      endfunction

      function void advance_delta(input logic [7:0] b, input bit last);
         // A delta cut off by track end still counts toward the tick.
         if (gather_vlq(b) || last) begin
            tick += vlq_acc;
            clear_vlq();
            phase = PH_STATUS;
         end
      endfunction

      function int unsigned data_bytes_for(input logic [7:0] status);
         case (status[7:4])
            4'hC, 4'hD:                   return 1;
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
            default:                      return 0;
         endcase
      endfunction

      function void expect_channel(input logic [1:0] len, input logic [7:0] d1,
                                   input logic [7:0] d2);
         rsp_beat_type r;
         r               = '0;
         r.event_tick    = tick;
         r.event_kind    = KindChannel;
         r.status_byte   = cur_status;
         r.first_data    = d1;
         r.second_data   = d2;
         r.event_length  = len;
         r.event_end     = 1'b1;
         r.quarter_tempo = tempo;
         awaited_events.insert(awaited_events.size(), r);
      endfunction

      function void expect_block(input bit valid, input logic [7:0] b,
                                 input logic [31:0] idx, input bit last);
         rsp_beat_type r;
         bit           meta;
         meta            = cur_status == StatusMeta;
         r               = '0;
         r.event_tick    = tick;
         r.event_kind    = meta ? KindMeta : KindSysex;
         r.status_byte   = cur_status;
         r.meta_code     = meta ? cur_meta : 8'h00;
         r.payload_byte  = valid ? b : 8'h00;
         r.payload_valid = valid;
         r.payload_index = valid ? idx[IndexW-1:0] : '0;
         r.event_end     = last;
         r.quarter_tempo = tempo;
         awaited_events.insert(awaited_events.size(), r);
      endfunction

      function void take_byte(input req_beat_type beat);
         logic [7:0]  b;
         logic [31:0] idx;
         bit          last;
         bit          redo;
         bit          consumed;
         bit          done;
         bit          valid;
         bit          fin;
         int unsigned need;
         int unsigned cap;
         b    = beat.track_byte;
         last = beat.track_end;
         redo = 1'b0;
         if (beat.track_start) restart();
         case (phase)
            PH_DELTA: advance_delta(b, last);
            PH_STATUS: begin
               if (b == StatusSysex || b == StatusEscape) begin
                  run_status = '0;
                  cur_status = b;
                  cur_meta   = '0;
                  clear_vlq();
                  if (last) expect_block(1'b0, '0, '0, 1'b1);
                  else phase = PH_LEN;
               end else if (b == StatusMeta) begin
                  run_status = '0;
                  cur_status = b;
                  cur_meta   = '0;
                  if (!last) phase = PH_MTYPE;
               end else begin
                  consumed = b[7];
                  if (consumed) run_status = b;
                  cur_status = run_status;
                  need       = data_bytes_for(cur_status);
                  phase      = PH_DELTA;
                  if (need == 0) begin
                     // A data byte under a status that takes none is parsed again as a delta.
                     expect_channel(2'd1, '0, '0);
                     redo = !consumed;
                  end else if (consumed) begin
                     if (last) expect_channel(2'd0, '0, '0);
                     else phase = PH_DATA1;
                  end else if (need == 1) begin
                     expect_channel(2'd2, b, '0);
                  end else if (last) begin
                     expect_channel(2'd0, '0, '0);
                     redo = 1'b1;
                  end else begin
                     held  = b;
                     phase = PH_DATA2;
                  end
               end
            end
            PH_MTYPE: begin
               cur_meta = b;
               clear_vlq();
               if (last) expect_block(1'b0, '0, '0, 1'b1);
               else phase = PH_LEN;
            end
            PH_LEN: begin
               done = gather_vlq(b);
               if (last) begin
                  expect_block(1'b0, '0, '0, 1'b1);
                  phase = PH_DELTA;
               end else if (done) begin
                  remaining = vlq_acc;
                  pos       = '0;
                  tempo_acc = '0;
                  if (remaining == 0) begin
                     expect_block(1'b0, '0, '0, 1'b1);
                     phase = PH_DELTA;
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end
               if (done || last) clear_vlq();
            end
            PH_PAYLOAD: begin
               idx   = pos;
               cap   = (cur_status == StatusMeta) ? PayloadBufferDefault - 2
                                                  : PayloadBufferDefault - 1;
               valid = idx < cap;
               // A Set Tempo value is kept only while the tempo still holds its default value.
               if (cur_status == StatusMeta && cur_meta == MetaSetTempo && idx < 3) begin
                  tempo_acc = {tempo_acc[15:0], b};
                  if (idx == 2 && tempo == TempoDefault) tempo = tempo_acc;
               end
               if (remaining != 0) remaining--;
               pos++;
               fin = remaining == 0 || last;
               if (valid || fin) expect_block(valid, b, idx, fin);
               if (fin) phase = PH_DELTA;
            end
            PH_DATA1: begin
               phase = PH_DELTA;
               if (data_bytes_for(cur_status) == 1) begin
                  expect_channel(2'd2, b, '0);
               end else if (last) begin
                  expect_channel(2'd0, '0, '0);
                  redo = 1'b1;
               end else begin
                  held  = b;
                  phase = PH_DATA2;
               end
            end
            PH_DATA2: begin
               expect_channel(2'd3, held, b);
               phase = PH_DELTA;
            end
            default: begin
               redo = 1'b1;
            end
         endcase
         if (redo) begin
            phase = PH_DELTA;
            clear_vlq();
            advance_delta(b, last);
         end
         if (last) begin
            phase = PH_DELTA;
            clear_vlq();
            remaining = '0;
            pos       = '0;
         end
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void match_event(input rsp_beat_type got);
         rsp_beat_type want;
         if (awaited_events.size() == 0) begin
            $error("result beat with nothing expected: 0x%0h", got);
            fail_count++;
            return;
         end
         want = awaited_events.pop_front();
         compare_field("event_tick", want.event_tick, got.event_tick);
         compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
         compare_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
         compare_field("meta_code", 32'(want.meta_code), 32'(got.meta_code));
         compare_field("first_data", 32'(want.first_data), 32'(got.first_data));
         compare_field("second_data", 32'(want.second_data), 32'(got.second_data));
         compare_field("event_length", 32'(want.event_length), 32'(got.event_length));
         compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
         compare_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
         compare_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
         compare_field("event_end", 32'(want.event_end), 32'(got.event_end));
         compare_field("quarter_tempo", 32'(want.quarter_tempo), 32'(got.quarter_tempo));
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_beat;

   track_event_checker board = new();
   logic [7:0]         track_body[$];
   int unsigned        bytes_accepted = 0;

   midi_track_chunk_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void append_byte(input logic [7:0] value);
      track_body.insert(track_body.size(), value);
   endfunction

   function automatic void push_vlq(input logic [27:0] value);
      int groups;
      groups = 1;
      while (groups < 4 && (value >> (7 * groups)) != 0) groups++;
      for (int g = groups - 1; g >= 0; g--)
         append_byte({g != 0, value[7*g +: 7]});
   endfunction

   function automatic void push_payload(input int unsigned len);
      push_vlq(28'(len));
      repeat (len) append_byte(8'($urandom));
   endfunction

   task automatic send_byte(input logic [7:0] value, input bit first, input bit last);
      req_beat_type beat;
      beat.track_byte  = value;
      beat.track_start = first;
      beat.track_end   = last;
      if (bytes_accepted < SteadySendFrom || bytes_accepted >= SteadySendTo) begin
         while ($urandom_range(99) < IdlePercent) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_beat  <= beat;
      do @(posedge clock); while (!req_ready);
      board.take_byte(beat);
      bytes_accepted++;
   endtask

   task automatic send_track(input bit with_start, input int unsigned last);
      for (int unsigned i = 0; i <= last; i++)
         send_byte(track_body[i], with_start && i == 0, i == last);
   endtask

   // Mostly well-formed events with random content, plus some stray bytes.
   task automatic build_track(input int unsigned events);
      int unsigned kind;
      int unsigned len;
      logic [7:0]  status;
      logic [7:0]  last_chan;
      logic [23:0] tempo_value;
      bit          running;
      track_body.delete();
      last_chan = '0;
      repeat (events) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: push_vlq(28'($urandom_range(127)));
            6, 7:             push_vlq(28'($urandom_range(16383)));
            8:                push_vlq(28'($urandom));
            default: begin
               // Longest delta form; a continuation flag on the fourth byte is ignored.
               repeat (3) append_byte({1'b1, 7'($urandom)});
               append_byte(8'($urandom));
            end
         endcase
         kind = $urandom_range(99);
         len  = ($urandom_range(49) == 0) ? $urandom_range(505, 520) : $urandom_range(12);
         if (kind < 50) begin
            running = last_chan != 0 && $urandom_range(2) == 0;
            status  = running ? last_chan : 8'($urandom_range(8'h80, 8'hEF));
            if (!running) append_byte(status);
            last_chan = status;
            repeat ((status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2)
               append_byte(($urandom_range(15) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(127)));
         end else if (kind < 55) begin
            status = 8'($urandom_range(8'hF1, 8'hFE));
            append_byte((status == StatusEscape) ? 8'hF1 : status);
            last_chan = '0;
         end else if (kind < 67) begin
            append_byte($urandom_range(1) ? StatusSysex : StatusEscape);
            push_payload(len);
            last_chan = '0;
         end else if (kind < 93) begin
            append_byte(StatusMeta);
            if ($urandom_range(4) < 2) begin
               append_byte(MetaSetTempo);
               tempo_value = ($urandom_range(7) == 0) ? TempoDefault : 24'($urandom);
               if ($urandom_range(3) != 0) begin
                  push_vlq(28'd3);
                  append_byte(tempo_value[23:16]);
                  append_byte(tempo_value[15:8]);
                  append_byte(tempo_value[7:0]);
               end else begin
                  push_payload(len);
               end
            end else begin
               append_byte(8'($urandom));
               push_payload(len);
            end
            last_chan = '0;
         end else begin
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
         end
      end
      append_byte(8'h00);
      append_byte(StatusMeta);
      append_byte(MetaEndOfTrack);
      append_byte(8'h00);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.match_event(rsp_beat);
   end

   initial begin : result_sink
      int unsigned cycle_no;
      int unsigned stall_left;
      cycle_no = 0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (cycle_no == HoldOffStart) begin
            // Hold results back long enough that the parser fills and stops taking bytes.
            rsp_ready  <= 1'b0;
            stall_left = HoldOffCycles;
            while (stall_left != 0) begin
               @(posedge clock);
               cycle_no++;
               stall_left--;
            end
         end
         if (cycle_no >= SteadyTakeFrom && cycle_no < SteadyTakeTo) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(99) >= IdlePercent);
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int unsigned cut;
      int unsigned random_stop;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Data with no running status yet, a note and its running-status twin, the
      // longest delta, a system status, a tempo change, an empty sysex and a
      // channel event cut short by track end.
      track_body = {8'h00, 8'h10, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h40, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC5, 8'h12, 8'h00, 8'hF1,
                    8'h00, StatusMeta, MetaSetTempo, 8'h03, 8'h0F, 8'h42, 8'h40,
                    8'h00, StatusSysex, 8'h00, 8'h00, 8'hA2, 8'h05};
      send_track(1'b1, track_body.size() - 1);

      // Sysex and meta payloads that run past the buffer cap.
      track_body = {8'h00, StatusSysex};
      push_payload(PayloadBufferDefault + 1);
      append_byte(8'h00);
      append_byte(StatusMeta);
      append_byte(MetaSequencerSpecific);
      push_payload(PayloadBufferDefault);
      append_byte(8'h00);
      append_byte(StatusMeta);
      append_byte(MetaEndOfTrack);
      append_byte(8'h00);
      send_track(1'b1, track_body.size() - 1);

      random_stop = bytes_accepted + RandomBytes;
      while (bytes_accepted < random_stop) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 30))
               send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
         end else begin
            build_track($urandom_range(1, 16));
            cut = track_body.size() - 1;
            if ($urandom_range(3) == 0) cut = $urandom_range(cut);
            send_track($urandom_range(9) != 0, cut);
         end
      end
      req_valid <= 1'b0;

      while (board.awaited_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.fail_count == 0 && board.awaited_events.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
